### hdl/idc_pkg.sv
`default_nettype none

package idc_pkg;

    // Field widths of one transaction
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    // Width of a day number counted from the first of January of year 0
    localparam int DNUM_W = 23;

    // Width of the reciprocal products used for the divisions by 100 and 400
    localparam int PROD_W = 30;

    // Reciprocal of 100 scaled by 2**21; exact for operands below 43690
    localparam logic [PROD_W-1:0] RECIP_100 = 30'd20972;
    localparam int SHIFT_100 = 21;
    localparam int SHIFT_400 = 23;

    // Largest count that fits the result field
    localparam logic [COUNT_W:0] COUNT_MAX = 23'd4194303;

    // Month codes
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // Status of one date as it leaves the date pipeline
    typedef struct packed {
        logic              ok;
        logic [DNUM_W-1:0] num;
    } date_info_t;

    // Days before the first of the month in a common year
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] s;
        case (m)
            MON_JAN: s = 9'd0;
            MON_FEB: s = 9'd31;
            MON_MAR: s = 9'd59;
            MON_APR: s = 9'd90;
            MON_MAY: s = 9'd120;
            MON_JUN: s = 9'd151;
            MON_JUL: s = 9'd181;
            MON_AUG: s = 9'd212;
            MON_SEP: s = 9'd243;
            MON_OCT: s = 9'd273;
            MON_NOV: s = 9'd304;
            MON_DEC: s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Length of the month, February depending on the leap flag
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### hdl/idc_date_num.sv
`default_nettype none

// Three-stage pipeline that checks one date and turns it into a day number.
module idc_date_num #(
    parameter int YEAR_MAX = 9999
) (
    input  wire logic                         clk,
    input  wire logic [idc_pkg::YEAR_W-1:0]   year,
    input  wire logic [idc_pkg::MONTH_W-1:0]  month,
    input  wire logic [idc_pkg::DAY_W-1:0]    day,
    output idc_pkg::date_info_t               info
);
    import idc_pkg::*;

    // Stage one: products for the year terms
    logic [YEAR_W-1:0]  y1_reg;
    logic [MONTH_W-1:0] m1_reg;
    logic [DAY_W-1:0]   d1_reg;
    logic [DNUM_W-1:0]  p365_reg, p365_next;
    logic [PROD_W-1:0]  pa_reg, pa_next;
    logic [PROD_W-1:0]  pb_reg, pb_next;
    logic [PROD_W-1:0]  pc_reg, pc_next;

    // Stage two: quotients, leap flag and validity
    logic [MONTH_W-1:0] m2_reg;
    logic [DAY_W-1:0]   d2_reg;
    logic [DNUM_W-1:0]  p365b_reg;
    logic [12:0]        q4_reg, q4_next;
    logic [8:0]         q100_reg, q100_next;
    logic [6:0]         q400_reg, q400_next;
    logic               leap_reg, leap_next;
    logic               ok_reg, ok_next;
    logic [8:0]         qy;

    // Stage three: day number
    date_info_t         info_reg, info_next;

    // Year times 365 and the scaled reciprocals for the century terms
    always_comb
    begin
        p365_next = DNUM_W'(year) * DNUM_W'(365);
        pa_next   = (PROD_W'(year) + PROD_W'(99)) * RECIP_100;
        pb_next   = (PROD_W'(year) + PROD_W'(399)) * RECIP_100;
        pc_next   = PROD_W'(year) * RECIP_100;
    end

    always_ff @(posedge clk)
    begin
        y1_reg   <= year;
        m1_reg   <= month;
        d1_reg   <= day;
        p365_reg <= p365_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        pc_reg   <= pc_next;
    end

    // Leap year test and range checks; a year is a century when its quotient
    // by 100 gives it back exactly
    always_comb
    begin
        q4_next   = 13'((15'(y1_reg) + 15'd3) >> 2);
        q100_next = pa_reg[SHIFT_100 +: 9];
        q400_next = pb_reg[SHIFT_400 +: 7];
        qy        = pc_reg[SHIFT_100 +: 9];
        leap_next = (y1_reg[1:0] == 2'b00) &&
                    (((16'(qy) * 16'd100) != 16'(y1_reg)) || (qy[1:0] == 2'b00));
        ok_next   = (32'(y1_reg) <= YEAR_MAX) && (m1_reg inside {[MON_JAN:MON_DEC]}) &&
                    (d1_reg != '0) && (d1_reg <= month_len(m1_reg, leap_next));
    end

    always_ff @(posedge clk)
    begin
        m2_reg    <= m1_reg;
        d2_reg    <= d1_reg;
        p365b_reg <= p365_reg;
        q4_reg    <= q4_next;
        q100_reg  <= q100_next;
        q400_reg  <= q400_next;
        leap_reg  <= leap_next;
        ok_reg    <= ok_next;
    end

    // Sum of the year, month and day terms
    always_comb
    begin
        info_next.ok  = ok_reg;
        info_next.num = p365b_reg + DNUM_W'(q4_reg) - DNUM_W'(q100_reg)
                      + DNUM_W'(q400_reg) + DNUM_W'(month_start(m2_reg))
                      + DNUM_W'(leap_reg && (m2_reg > MON_FEB))
                      + DNUM_W'(d2_reg) - DNUM_W'(1);
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign info = info_reg;

endmodule

`default_nettype wire

### hdl/inclusive_date_day_count.sv
`default_nettype none

// Inclusive day count between two Gregorian dates. A transaction is taken on
// every clock edge with start high; busy is always low, so one date pair can
// follow another in every cycle. The result appears on day_count and
// invalid_date for one cycle with done high, and must be captured then since
// it cannot be held back. Each pair passes through the pipeline: input
// register, reciprocal multipliers for the century terms, quotient and leap
// check, day number sum, then difference and saturation into the result
// register. A month, day or year out of range gives invalid_date high and a
// count of zero; counts beyond the 22-bit field saturate.
module inclusive_date_day_count #(
    parameter int YEAR_MAX = 9999
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [idc_pkg::YEAR_W-1:0]   first_year,
    input  wire logic [idc_pkg::MONTH_W-1:0]  first_month,
    input  wire logic [idc_pkg::DAY_W-1:0]    first_day,
    input  wire logic [idc_pkg::YEAR_W-1:0]   second_year,
    input  wire logic [idc_pkg::MONTH_W-1:0]  second_month,
    input  wire logic [idc_pkg::DAY_W-1:0]    second_day,
    output      logic                         done,
    output      logic [idc_pkg::COUNT_W-1:0]  day_count,
    output      logic                         invalid_date
);
    import idc_pkg::*;

    localparam int LAT = 4;

    logic               accept;
    logic [YEAR_W-1:0]  fy_reg, sy_reg;
    logic [MONTH_W-1:0] fm_reg, sm_reg;
    logic [DAY_W-1:0]   fd_reg, sd_reg;
    logic [LAT-1:0]     vld_reg, vld_next;
    date_info_t         info_a, info_b;
    logic [DNUM_W-1:0]  diff;
    logic [COUNT_W:0]   cnt;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               inv_reg, inv_next;
    logic               done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fy_reg <= first_year;
            fm_reg <= first_month;
            fd_reg <= first_day;
            sy_reg <= second_year;
            sm_reg <= second_month;
            sd_reg <= second_day;
        end
    end

    // Day number of each date
    idc_date_num #(
        .YEAR_MAX (YEAR_MAX)
    ) u_date_a (
        .clk   (clk),
        .year  (fy_reg),
        .month (fm_reg),
        .day   (fd_reg),
        .info  (info_a)
    );

    idc_date_num #(
        .YEAR_MAX (YEAR_MAX)
    ) u_date_b (
        .clk   (clk),
        .year  (sy_reg),
        .month (sm_reg),
        .day   (sd_reg),
        .info  (info_b)
    );

    // Absolute difference plus one, saturated, zero when either date is bad
    always_comb
    begin
        diff     = (info_a.num > info_b.num) ? (info_a.num - info_b.num)
                                             : (info_b.num - info_a.num);
        cnt      = (COUNT_W + 1)'(diff) + (COUNT_W + 1)'(1);
        inv_next = !(info_a.ok && info_b.ok);
        if (inv_next)
        begin
            count_next = '0;
        end
        else if (cnt > COUNT_MAX)
        begin
            count_next = COUNT_MAX[COUNT_W-1:0];
        end
        else
        begin
            count_next = cnt[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        inv_reg   <= inv_next;
    end

    // Transaction tracking along the pipeline
    assign vld_next = {vld_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[LAT-1];
        end
    end

    assign done         = done_reg;
    assign day_count    = count_reg;
    assign invalid_date = inv_reg;

`ifndef SYNTHESIS
    // The strobe is sampled at the edge after the one that loads the result register.
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT + 1))
        else $error("result strobe without a matching transaction");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LAT + 1) done)
        else $error("accepted transaction produced no result");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && invalid_date |-> day_count == '0)
        else $error("invalid date with a non-zero count");

    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !invalid_date |-> day_count != '0)
        else $error("valid dates with a zero count");
`endif

endmodule

`default_nettype wire

### test/tb_inclusive_date_day_count.sv
`timescale 1ns / 100ps

module tb_inclusive_date_day_count;
    import idc_pkg::*;

    localparam int YEAR_MAX     = 9999;
    localparam int CLK_PERIOD   = 12;
    localparam int LATENCY      = 4;
    localparam int REPORT_LIMIT = 10;
    localparam longint COUNT_SAT = 4194303;

    // One expected result of a date pair
    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               invalid;
    } span_t;

    // Scoreboard: predicts the span of each accepted date pair and
    // compares it with the strobed results in order.
    class date_span_board;
        span_t pending_spans[$];
        int    mismatches;
        int    failures;

        function new();
            mismatches = 0;
            failures   = 0;
        endfunction

        // Leap rule of the Gregorian calendar; year zero counts as leap.
        function bit is_leap(longint y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        // Days in month m of year y; zero for a month that does not exist.
        function longint days_in_month(logic [MONTH_W-1:0] m, longint y);
            case (m)
                MON_FEB: return is_leap(y) ? 29 : 28;
                MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
                MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                    return 31;
                default: return 0;
            endcase
        endfunction

        function bit real_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                               logic [DAY_W-1:0] d);
            if (y > YEAR_MAX || m < MON_JAN || m > MON_DEC || d == 0)
                return 0;
            return d <= days_in_month(m, longint'(y));
        endfunction

        // Days elapsed since the first of January of year zero.
        function longint day_ordinal(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                     logic [DAY_W-1:0] d);
            longint yy;
            longint n;
            longint first_of_month[13];
            first_of_month = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
            yy = longint'(y);
            n  = yy * 365 + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
            n += first_of_month[m];
            if (m > MON_FEB && is_leap(yy))
                n += 1;
            return n + longint'(d) - 1;
        endfunction

        // Note an accepted transaction and queue its expected result.
        function void note_request(logic [YEAR_W-1:0] y1, logic [MONTH_W-1:0] m1,
                                   logic [DAY_W-1:0] d1, logic [YEAR_W-1:0] y2,
                                   logic [MONTH_W-1:0] m2, logic [DAY_W-1:0] d2);
            span_t  s;
            longint a;
            longint b;
            longint cnt;
            if (!real_date(y1, m1, d1) || !real_date(y2, m2, d2))
            begin
                s.count   = '0;
                s.invalid = 1'b1;
            end
            else
            begin
                a   = day_ordinal(y1, m1, d1);
                b   = day_ordinal(y2, m2, d2);
                cnt = (a > b) ? (a - b + 1) : (b - a + 1);
                if (cnt > COUNT_SAT)
                    cnt = COUNT_SAT;
                s.count   = cnt[COUNT_W-1:0];
                s.invalid = 1'b0;
            end
            pending_spans.insert(pending_spans.size(), s);
        endfunction

        // Compare one strobed result with the oldest expectation.
        function void check_result(logic [COUNT_W-1:0] count, logic invalid);
            span_t s;
            if (pending_spans.size() == 0)
            begin
                failures++;
                if (mismatches < REPORT_LIMIT)
                    $display("Unexpected result: day_count=%0d invalid_date=%0b",
                             count, invalid);
                mismatches++;
                return;
            end
            s = pending_spans.pop_front();
            if (count !== s.count || invalid !== s.invalid)
            begin
                failures++;
                if (mismatches < REPORT_LIMIT)
                    $display("Mismatch: day_count exp %0d got %0d, invalid_date exp %0b got %0b",
                             s.count, count, s.invalid, invalid);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_spans.size();
        endfunction

        // Any expectation still waiting at the end is a failure.
        function void close_out();
            if (pending_spans.size() != 0)
            begin
                failures++;
                $display("%0d expected results never arrived", pending_spans.size());
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic               done;
    logic [COUNT_W-1:0] day_count;
    logic               invalid_date;

    date_span_board board;
    int             idle_pct;

    inclusive_date_day_count #(
        .YEAR_MAX(YEAR_MAX)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .first_year  (first_year),
        .first_month (first_month),
        .first_day   (first_day),
        .second_year (second_year),
        .second_month(second_month),
        .second_day  (second_day),
        .done        (done),
        .day_count   (day_count),
        .invalid_date(invalid_date)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog for a run that hangs.
    initial
    begin
        #(200000 * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    // Observe accepted transactions and strobed results at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (start === 1'b1 && busy === 1'b0)
                board.note_request(first_year, first_month, first_day,
                                   second_year, second_month, second_day);
            if (done === 1'b1)
                board.check_result(day_count, invalid_date);
        end
    end

    // Offer one date pair and hold it until the block takes it.
    task automatic drive_pair(input logic [YEAR_W-1:0] y1, input logic [MONTH_W-1:0] m1,
                              input logic [DAY_W-1:0] d1, input logic [YEAR_W-1:0] y2,
                              input logic [MONTH_W-1:0] m2, input logic [DAY_W-1:0] d2);
        @(negedge clk);
        start        <= 1'b1;
        first_year   <= y1;
        first_month  <= m1;
        first_day    <= d1;
        second_year  <= y2;
        second_month <= m2;
        second_day   <= d2;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Leave start low for one cycle.
    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Hold off until every queued result has come back.
    task automatic drain_results();
        idle_cycle();
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // A year biased towards the century and leap boundaries.
    function automatic logic [YEAR_W-1:0] pick_year();
        int corner_years[13];
        corner_years = '{0, 1, 4, 99, 100, 399, 400, 1600, 1900, 2000, 2100, 9996, 9999};
        if ($urandom_range(99) < 30)
            return YEAR_W'(corner_years[$urandom_range(12)]);
        return YEAR_W'($urandom_range(YEAR_MAX));
    endfunction

    // A day that exists in the given month, often at its first or last day.
    function automatic logic [DAY_W-1:0] pick_day(logic [MONTH_W-1:0] m,
                                                  logic [YEAR_W-1:0] y);
        int len;
        len = int'(board.days_in_month(m, longint'(y)));
        if ($urandom_range(99) < 20)
            return ($urandom_range(1) == 1) ? DAY_W'(len) : DAY_W'(1);
        return DAY_W'($urandom_range(len, 1));
    endfunction

    // Random date pair: mostly real dates, some entirely random bit patterns.
    task automatic drive_random_pair();
        logic [YEAR_W-1:0]  y1;
        logic [YEAR_W-1:0]  y2;
        logic [MONTH_W-1:0] m1;
        logic [MONTH_W-1:0] m2;
        logic [DAY_W-1:0]   d1;
        logic [DAY_W-1:0]   d2;
        int                 sel;
        sel = $urandom_range(99);
        if (sel < 12)
        begin
            y1 = YEAR_W'($urandom_range(16383));
            m1 = MONTH_W'($urandom_range(15));
            d1 = DAY_W'($urandom_range(31));
            y2 = YEAR_W'($urandom_range(16383));
            m2 = MONTH_W'($urandom_range(15));
            d2 = DAY_W'($urandom_range(31));
        end
        else
        begin
            y1 = pick_year();
            m1 = MONTH_W'($urandom_range(MON_DEC, MON_JAN));
            d1 = pick_day(m1, y1);
            if (sel < 20)
            begin
                // The very same date on both sides.
                y2 = y1;
                m2 = m1;
                d2 = d1;
            end
            else
            begin
                if (sel < 45)
                    y2 = (y1 == YEAR_MAX) ? y1 : y1 + YEAR_W'($urandom_range(1));
                else
                    y2 = pick_year();
                m2 = MONTH_W'($urandom_range(MON_DEC, MON_JAN));
                d2 = pick_day(m2, y2);
            end
        end
        drive_pair(y1, m1, d1, y2, m2, d2);
    endtask

    // Directed pairs: field extremes and each calendar special case.
    task automatic run_directed();
        drive_pair(14'd2024, MON_MAR, 5'd15, 14'd2024, MON_MAR, 5'd15);
        drive_pair(14'd0, MON_JAN, 5'd1, 14'd9999, MON_DEC, 5'd31);
        drive_pair(14'd9999, MON_DEC, 5'd31, 14'd0, MON_JAN, 5'd1);
        drive_pair(14'd2000, MON_FEB, 5'd29, 14'd2000, MON_MAR, 5'd1);
        drive_pair(14'd1900, MON_FEB, 5'd29, 14'd1900, MON_MAR, 5'd1);
        drive_pair(14'd0, MON_FEB, 5'd29, 14'd1, MON_JAN, 5'd1);
        drive_pair(14'd2023, MON_FEB, 5'd28, 14'd2023, MON_FEB, 5'd29);
        drive_pair(14'd2024, MON_FEB, 5'd29, 14'd2023, MON_FEB, 5'd28);
        drive_pair(14'd2100, MON_FEB, 5'd28, 14'd2100, MON_FEB, 5'd29);
        drive_pair(14'd1999, MON_DEC, 5'd31, 14'd2000, MON_JAN, 5'd1);
        drive_pair(14'd2020, 4'd0, 5'd10, 14'd2020, MON_JAN, 5'd10);
        drive_pair(14'd2020, MON_JAN, 5'd10, 14'd2020, 4'd13, 5'd10);
        drive_pair(14'd2020, 4'd15, 5'd31, 14'd2020, MON_JAN, 5'd1);
        drive_pair(14'd2020, MON_JAN, 5'd0, 14'd2020, MON_JAN, 5'd1);
        drive_pair(14'd2020, MON_APR, 5'd31, 14'd2020, MON_MAY, 5'd1);
        drive_pair(14'd2020, MON_MAY, 5'd31, 14'd2020, MON_JUN, 5'd30);
        drive_pair(14'd2020, MON_JAN, 5'd31, 14'd2020, MON_DEC, 5'd31);
        drive_pair(14'd10000, MON_JAN, 5'd1, 14'd2020, MON_JAN, 5'd1);
        drive_pair(14'd2020, MON_JAN, 5'd1, 14'd16383, MON_DEC, 5'd31);
        drive_pair(14'd9999, MON_FEB, 5'd28, 14'd9999, MON_FEB, 5'd29);
        drive_pair(14'd16383, 4'd15, 5'd31, 14'd16383, 4'd15, 5'd31);
        drive_pair(14'd400, MON_FEB, 5'd29, 14'd100, MON_FEB, 5'd28);
    endtask

    // Main sequence: reset, directed pairs, then random phases.
    initial
    begin
        int sender_idle[4];
        sender_idle = '{0, 82, 16, 0};
        board        = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        first_year   = '0;
        first_month  = MON_JAN;
        first_day    = 5'd1;
        second_year  = '0;
        second_month = MON_JAN;
        second_day   = 5'd1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = sender_idle[phase];
            for (int n = 0; n < 320; n++)
            begin
                while ($urandom_range(99) < idle_pct)
                    idle_cycle();
                drive_random_pair();
            end
            // Pause until the pipeline has emptied before the next phase.
            drain_results();
        end

        repeat (LATENCY * 2) @(posedge clk);
        board.close_out();
        if (board.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
